// ===== src/assert_macros.svh =====
// Assertion macros used by the SGD matrix factorization core.
// Needs a clock named clk and an active-high reset named rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define CHK_SAME(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");

// Next-cycle implication.
`define CHK_NEXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");

`endif

// ===== src/sgdmf_pkg.sv =====
// Shared types, codes and constants of the SGD matrix factorization core.
// No dependencies.
package sgdmf_pkg;

  localparam int MAX_USERS   = 1024;
  localparam int MAX_ITEMS   = 1024;
  localparam int MAX_FACTORS = 16;

  localparam int UIDX_W = 10;
  localparam int IIDX_W = 10;
  localparam int FIDX_W = 4;
  localparam int UADDR_W = UIDX_W + FIDX_W;
  localparam int IADDR_W = IIDX_W + FIDX_W;
  localparam int KCNT_W = 5;

  localparam logic [2:0] REQ_WR_USER = 3'd0;
  localparam logic [2:0] REQ_WR_ITEM = 3'd1;
  localparam logic [2:0] REQ_TRAIN   = 3'd2;
  localparam logic [2:0] REQ_EVAL    = 3'd3;
  localparam logic [2:0] REQ_CLOSE   = 3'd4;
  localparam logic [2:0] REQ_RD_USER = 3'd5;
  localparam logic [2:0] REQ_RD_ITEM = 3'd6;

  localparam logic [1:0] CFG_LEARN_RATE = 2'd0;
  localparam logic [1:0] CFG_REG_WEIGHT = 2'd1;
  localparam logic [1:0] CFG_THRESHOLD  = 2'd2;
  localparam logic [1:0] CFG_FACTORS    = 2'd3;

  localparam logic [15:0] LEARN_RATE_RST = 16'd13107;
  localparam logic [15:0] REG_WEIGHT_RST = 16'd1311;
  localparam logic [47:0] THRESHOLD_RST  = 48'd1049;
  localparam logic [4:0]  FACTORS_RST    = 5'd16;

  typedef struct packed {
    logic [2:0]         req_type;
    logic [9:0]         user_index;
    logic [9:0]         item_index;
    logic [3:0]         factor_index;
    logic signed [31:0] factor_value;
    logic [7:0]         rating_value;
  } req_t;

  typedef struct packed {
    logic signed [31:0] read_value;
    logic [47:0]        error_total;
    logic               below_threshold;
    logic               saturated;
  } rsp_t;

  // Saturate to 32-bit signed; MSB of the result is the saturation flag.
  function automatic logic [32:0] sat32(input logic signed [65:0] x);
    logic [32:0] r;
    if (x > 66'sd2147483647) begin
      r = {1'b1, 32'h7FFF_FFFF};
    end else if (x < -66'sd2147483648) begin
      r = {1'b1, 32'h8000_0000};
    end else begin
      r = {1'b0, x[31:0]};
    end
    return r;
  endfunction

endpackage

// ===== src/sgd_matrix_factorization_core.sv =====
// SGD matrix factorization core: factor tables, one shared multiplier, sequencer.
// Depends on sgdmf_pkg and assert_macros.svh.
//
//  channel | signals                           | beat
//  --------+-----------------------------------+-------------------------------
//  request | req_valid, req_ready, req         | one command (write/train/...)
//  result  | rsp_valid, rsp_ready, rsp         | one result per command
//  config  | cfg_we, cfg_index, cfg_data       | one register write, no stall
//
// The single 33x33 multiplier is shared: every product of the dot, update and
// penalty terms passes through it one at a time, and wide products are split
// into two halves.
// Reset (rst, synchronous) restores the default registers and clears the epoch
// accumulator; the factor tables are not cleared and hold garbage until loaded.
// req_ready is high only in the idle state; a finished result sits in the output
// register, so a new beat can be taken while the previous result waits.
module sgd_matrix_factorization_core import sgdmf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_ready,
  input  req_t        req,
  output logic        rsp_valid,
  input  logic        rsp_ready,
  output rsp_t        rsp,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [47:0] cfg_data
);

`include "assert_macros.svh"

  // Sequencer states
  localparam logic [4:0] ST_IDLE    = 5'd0;
  localparam logic [4:0] ST_RD_WAIT = 5'd1;
  localparam logic [4:0] ST_DONE    = 5'd2;
  localparam logic [4:0] ST_DOT_RD  = 5'd3;
  localparam logic [4:0] ST_DOT_MUL = 5'd4;
  localparam logic [4:0] ST_DOT_ACC = 5'd5;
  localparam logic [4:0] ST_ERR     = 5'd6;
  localparam logic [4:0] ST_UP_RD   = 5'd7;
  localparam logic [4:0] ST_UP_LAT  = 5'd8;
  localparam logic [4:0] ST_UP_G    = 5'd9;
  localparam logic [4:0] ST_UP_P    = 5'd10;
  localparam logic [4:0] ST_UP_D    = 5'd11;
  localparam logic [4:0] ST_MUL_LO  = 5'd12;
  localparam logic [4:0] ST_MUL_HI  = 5'd13;
  localparam logic [4:0] ST_MUL_SUM = 5'd14;
  localparam logic [4:0] ST_UP_B    = 5'd15;
  localparam logic [4:0] ST_EV_E    = 5'd16;
  localparam logic [4:0] ST_EV_E2   = 5'd17;
  localparam logic [4:0] ST_EV_RD   = 5'd18;
  localparam logic [4:0] ST_EV_LAT  = 5'd19;
  localparam logic [4:0] ST_EV_I    = 5'd20;
  localparam logic [4:0] ST_EV_S    = 5'd21;
  localparam logic [4:0] ST_EV_R4   = 5'd22;
  localparam logic [4:0] ST_EV_ACC  = 5'd23;

  localparam logic [47:0] ACC_MAX = '1;

  // Configuration
  logic [15:0] learn_rate, reg_weight;
  logic [47:0] error_threshold;
  logic [4:0]  factor_count;

  // Factor tables
  logic signed [31:0] umem [MAX_USERS*MAX_FACTORS];
  logic signed [31:0] imem [MAX_ITEMS*MAX_FACTORS];
  logic signed [31:0] u_rdata, i_rdata;
  logic [UADDR_W-1:0] u_raddr, u_waddr;
  logic [IADDR_W-1:0] i_raddr, i_waddr;
  logic               u_we, i_we;
  logic signed [31:0] u_wdata, i_wdata;

  // Sequencer and datapath registers
  logic [4:0]         state;
  logic [KCNT_W-1:0]  k;
  logic [UIDX_W-1:0]  ui_r;
  logic [IIDX_W-1:0]  ii_r;
  logic [7:0]         rating_r;
  logic               op_eval, upd_item, sat_flag, rd_item;
  logic signed [47:0] dot;
  logic signed [31:0] err, uf, itf;
  logic signed [65:0] prod, full;
  logic signed [45:0] grad;
  logic signed [46:0] diff;
  logic signed [65:0] low;
  logic [63:0]        sq;
  logic [47:0]        sum, err_acc;
  logic signed [31:0] res_read;
  logic [47:0]        res_total;
  logic               res_below;

  // Combinational helpers
  logic [KCNT_W-1:0]  kc;
  logic               accept, user_ok, item_ok;
  logic signed [31:0] fsel, osel;
  logic signed [32:0] coef, mul_a, mul_b;
  logic signed [65:0] r20, r16, full_r16, full_r17;
  logic signed [49:0] err_wide;
  logic [32:0]        err_sat, newf;
  logic [63:0]        sq_sum;
  logic [47:0]        acc_room;

  assign accept    = req_valid && req_ready;
  assign req_ready = (state == ST_IDLE) && !rst;

  always_comb begin
    kc = (factor_count > KCNT_W'(MAX_FACTORS)) ? KCNT_W'(MAX_FACTORS) : factor_count;
    user_ok = (int'(req.user_index) < MAX_USERS);
    item_ok = (int'(req.item_index) < MAX_ITEMS);
    fsel = upd_item ? itf : uf;
    osel = upd_item ? uf : itf;
    coef = {17'd0, (op_eval ? reg_weight : learn_rate)};

    // Operand select for the shared multiplier
    case (state)
      ST_DOT_MUL: begin mul_a = 33'(u_rdata); mul_b = 33'(i_rdata); end
      ST_UP_G:    begin mul_a = 33'(err);     mul_b = 33'(osel);    end
      ST_UP_P:    begin mul_a = {17'd0, reg_weight}; mul_b = 33'(fsel); end
      ST_MUL_LO:  begin mul_a = coef; mul_b = {10'd0, diff[22:0]}; end
      ST_MUL_HI:  begin mul_a = coef; mul_b = {{9{diff[46]}}, diff[46:23]}; end
      ST_EV_E:    begin mul_a = 33'(err);     mul_b = 33'(err);     end
      ST_EV_LAT:  begin mul_a = 33'(u_rdata); mul_b = 33'(u_rdata); end
      ST_EV_I:    begin mul_a = 33'(itf);     mul_b = 33'(itf);     end
      default:    begin mul_a = '0;           mul_b = '0;           end
    endcase

    // Round half up to the target fraction
    r20      = (prod + 66'sd524288) >>> 20;
    r16      = (prod + 66'sd32768) >>> 16;
    full_r16 = (full + 66'sd32768) >>> 16;
    full_r17 = (full + 66'sd65536) >>> 17;

    err_wide = $signed({22'd0, rating_r, 20'd0}) - $signed({{2{dot[47]}}, dot});
    err_sat  = sat32(66'(err_wide));
    newf     = sat32(66'(fsel) + full_r16);
    sq_sum   = prod[63:0] + sq + 64'd524288;
    acc_room = ACC_MAX - err_acc;

    // Table ports: host access in idle, row sweep otherwise
    if (state == ST_IDLE) begin
      u_raddr = {req.user_index, req.factor_index};
      i_raddr = {req.item_index, req.factor_index};
    end else begin
      u_raddr = {ui_r, k[FIDX_W-1:0]};
      i_raddr = {ii_r, k[FIDX_W-1:0]};
    end
    u_we = 1'b0;
    i_we = 1'b0;
    u_waddr = {ui_r, k[FIDX_W-1:0]};
    i_waddr = {ii_r, k[FIDX_W-1:0]};
    u_wdata = newf[31:0];
    i_wdata = newf[31:0];
    if (accept && req.req_type == REQ_WR_USER && user_ok) begin
      u_we = 1'b1;
      u_waddr = {req.user_index, req.factor_index};
      u_wdata = req.factor_value;
    end else if (state == ST_UP_B && !upd_item) begin
      u_we = 1'b1;
    end
    if (accept && req.req_type == REQ_WR_ITEM && item_ok) begin
      i_we = 1'b1;
      i_waddr = {req.item_index, req.factor_index};
      i_wdata = req.factor_value;
    end else if (state == ST_UP_B && upd_item) begin
      i_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (u_we) begin
      umem[u_waddr] <= u_wdata;
    end
    u_rdata <= umem[u_raddr];
  end

  always_ff @(posedge clk) begin
    if (i_we) begin
      imem[i_waddr] <= i_wdata;
    end
    i_rdata <= imem[i_raddr];
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      learn_rate      <= LEARN_RATE_RST;
      reg_weight      <= REG_WEIGHT_RST;
      error_threshold <= THRESHOLD_RST;
      factor_count    <= FACTORS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LEARN_RATE: learn_rate      <= cfg_data[15:0];
        CFG_REG_WEIGHT: reg_weight      <= cfg_data[15:0];
        CFG_THRESHOLD:  error_threshold <= cfg_data;
        CFG_FACTORS:    factor_count    <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // Shared multiplier, one product per cycle
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
      err_acc   <= '0;
    end else begin
      // ST_DONE refills the output register itself on a taken beat
      if (rsp_valid && rsp_ready && state != ST_DONE) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            ui_r      <= req.user_index;
            ii_r      <= req.item_index;
            rating_r  <= req.rating_value;
            op_eval   <= (req.req_type == REQ_EVAL);
            rd_item   <= (req.req_type == REQ_RD_ITEM);
            sat_flag  <= 1'b0;
            res_read  <= '0;
            res_total <= (req.req_type == REQ_CLOSE) ? err_acc : '0;
            res_below <= (req.req_type == REQ_CLOSE) && (err_acc < error_threshold);
            dot       <= '0;
            k         <= '0;
            case (req.req_type)
              REQ_TRAIN, REQ_EVAL: begin
                state <= (user_ok && item_ok) ? ST_DOT_RD : ST_DONE;
              end
              REQ_CLOSE: begin
                err_acc   <= '0;
                state     <= ST_DONE;
              end
              REQ_RD_USER: state <= user_ok ? ST_RD_WAIT : ST_DONE;
              REQ_RD_ITEM: state <= item_ok ? ST_RD_WAIT : ST_DONE;
              default:     state <= ST_DONE;
            endcase
          end
        end
        ST_RD_WAIT: begin
          res_read <= rd_item ? i_rdata : u_rdata;
          state    <= ST_DONE;
        end
        ST_DONE: begin
          if (!rsp_valid || rsp_ready) begin
            rsp.read_value      <= res_read;
            rsp.error_total     <= res_total;
            rsp.below_threshold <= res_below;
            rsp.saturated       <= sat_flag;
            rsp_valid           <= 1'b1;
            state               <= ST_IDLE;
          end
        end
        // Dot product pass
        ST_DOT_RD: begin
          state <= (k == kc) ? ST_ERR : ST_DOT_MUL;
        end
        ST_DOT_MUL: begin
          k     <= k + 1'b1;
          state <= ST_DOT_ACC;
        end
        ST_DOT_ACC: begin
          dot   <= dot + r20[47:0];
          state <= ST_DOT_RD;
        end
        ST_ERR: begin
          err      <= err_sat[31:0];
          sat_flag <= sat_flag | err_sat[32];
          k        <= '0;
          state    <= op_eval ? ST_EV_E : ST_UP_RD;
        end
        // Train: user then item update per factor
        ST_UP_RD: begin
          state <= (k == kc) ? ST_DONE : ST_UP_LAT;
        end
        ST_UP_LAT: begin
          uf       <= u_rdata;
          itf      <= i_rdata;
          upd_item <= 1'b0;
          state    <= ST_UP_G;
        end
        ST_UP_G: state <= ST_UP_P;
        ST_UP_P: begin
          grad  <= {r20[44:0], 1'b0};
          state <= ST_UP_D;
        end
        ST_UP_D: begin
          diff  <= 47'(grad) - 47'(r16);
          state <= ST_MUL_LO;
        end
        // coef * diff, split into a low and a high partial product
        ST_MUL_LO: state <= ST_MUL_HI;
        ST_MUL_HI: begin
          low   <= prod;
          state <= ST_MUL_SUM;
        end
        ST_MUL_SUM: begin
          full  <= (prod <<< 23) + low;
          state <= op_eval ? ST_EV_R4 : ST_UP_B;
        end
        ST_UP_B: begin
          sat_flag <= sat_flag | newf[32];
          if (!upd_item) begin
            uf       <= newf[31:0];
            upd_item <= 1'b1;
            state    <= ST_UP_G;
          end else begin
            itf   <= newf[31:0];
            k     <= k + 1'b1;
            state <= ST_UP_RD;
          end
        end
        // Evaluate: error^2 plus reg/2 * (u^2 + i^2)
        ST_EV_E: state <= ST_EV_E2;
        ST_EV_E2: begin
          sum   <= r20[47:0];
          state <= ST_EV_RD;
        end
        ST_EV_RD: begin
          state <= (k == kc) ? ST_EV_ACC : ST_EV_LAT;
        end
        ST_EV_LAT: begin
          itf   <= i_rdata;
          state <= ST_EV_I;
        end
        ST_EV_I: begin
          sq    <= prod[63:0];
          state <= ST_EV_S;
        end
        ST_EV_S: begin
          diff  <= {3'd0, sq_sum[63:20]};
          state <= ST_MUL_LO;
        end
        ST_EV_R4: begin
          sum   <= sum + full_r17[47:0];
          k     <= k + 1'b1;
          state <= ST_EV_RD;
        end
        ST_EV_ACC: begin
          if (sum > acc_room) begin
            err_acc  <= ACC_MAX;
            sat_flag <= 1'b1;
          end else begin
            err_acc <= err_acc + sum;
          end
          state <= ST_DONE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Checks
  `CHK_NEXT(a_accept_leaves_idle, accept, state != ST_IDLE)
  `CHK_NEXT(a_done_delivers, state == ST_DONE && (!rsp_valid || rsp_ready),
            rsp_valid && state == ST_IDLE)
  `CHK_NEXT(a_close_clears, accept && req.req_type == REQ_CLOSE, err_acc == '0)
  `CHK_SAME(a_k_bounded, state != ST_IDLE, k <= kc)

endmodule
